[rtl/caw_pkg.sv]
package caw_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RECORD_POSITION = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_START    = 1'd1;

   // CIGAR characters
   localparam logic [7:0] CHAR_0  = 8'h30;
   localparam logic [7:0] CHAR_9  = 8'h39;
   localparam logic [7:0] CHAR_M  = 8'h4D;
   localparam logic [7:0] CHAR_EQ = 8'h3D;
   localparam logic [7:0] CHAR_X  = 8'h58;
   localparam logic [7:0] CHAR_I  = 8'h49;
   localparam logic [7:0] CHAR_S  = 8'h53;
   localparam logic [7:0] CHAR_D  = 8'h44;
   localparam logic [7:0] CHAR_N  = 8'h4E;
   localparam logic [7:0] CHAR_H  = 8'h48;
   localparam logic [7:0] CHAR_P  = 8'h50;

   localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

   // Segment classes
   typedef enum logic [2:0] {
      OP_COPY      = 3'd0,
      OP_READ_SKIP = 3'd1,
      OP_REF_SKIP  = 3'd2,
      OP_CLIP      = 3'd3,
      OP_BAD       = 3'd4
   } op_class_type;

   typedef struct packed {
      logic [7:0] cigar_char;
      logic       last_char;
   } req_type;

   typedef struct packed {
      op_class_type op_class;
      logic [31:0]  read_offset;
      logic [31:0]  ref_column;
      logic [31:0]  run_length;
      logic [31:0]  end_position;
      logic         record_done;
   } rsp_type;

   // Per-record walker state
   typedef struct packed {
      logic [31:0] length_acc;
      logic [31:0] read_cursor;
      logic [31:0] ref_consumed;
      logic        error_seen;
   } walk_state_type;

endpackage

[rtl/caw_step.sv]
module caw_step (
   input  caw_pkg::walk_state_type state,
   input  caw_pkg::req_type        item,
   input  logic [31:0]             col_base,
   input  logic [31:0]             end_base,
   output caw_pkg::walk_state_type state_next,
   output logic                    emit,
   output caw_pkg::rsp_type        result
);
   import caw_pkg::*;

   logic        is_digit;
   logic [35:0] acc_wide;
   logic [31:0] acc_sat;
   logic [31:0] run;
   logic [31:0] read_add;
   logic [31:0] ref_add;
   op_class_type cls;

   // Decimal run length: acc * 10 + digit, saturating
   assign is_digit = (item.cigar_char >= CHAR_0) && (item.cigar_char <= CHAR_9);
   assign acc_wide = ({4'd0, state.length_acc} << 3) + ({4'd0, state.length_acc} << 1)
                   + {32'd0, item.cigar_char[3:0]};
   assign acc_sat  = (acc_wide[35:32] != 4'd0) ? LEN_MAX : acc_wide[31:0];

   always_comb begin
      state_next = state;
      emit       = 1'b0;
      cls        = OP_CLIP;
      run        = '0;
      read_add   = '0;
      ref_add    = '0;
      if (state.error_seen) begin
         // rest of a bad record is dropped; only the last char reports
         cls  = OP_BAD;
         emit = item.last_char;
      end else if (is_digit) begin
         state_next.length_acc = acc_sat;
         if (item.last_char) begin
            run  = acc_sat;
            emit = 1'b1;
         end
      end else begin
         run  = state.length_acc;
         emit = 1'b1;
         state_next.length_acc = '0;
         unique case (item.cigar_char)
            CHAR_M, CHAR_EQ, CHAR_X: begin
               cls      = OP_COPY;
               read_add = state.length_acc;
               ref_add  = state.length_acc;
            end
            CHAR_I, CHAR_S: begin
               cls      = OP_READ_SKIP;
               read_add = state.length_acc;
            end
            CHAR_D, CHAR_N: begin
               cls     = OP_REF_SKIP;
               ref_add = state.length_acc;
            end
            CHAR_H, CHAR_P: begin
               cls = OP_CLIP;
            end
            default: begin
               cls = OP_BAD;
               state_next.error_seen = 1'b1;
            end
         endcase
         state_next.read_cursor  = state.read_cursor + read_add;
         state_next.ref_consumed = state.ref_consumed + ref_add;
      end

      // Segment descriptor, positions taken before the cursors move
      result.op_class     = cls;
      result.read_offset  = state.read_cursor;
      result.ref_column   = col_base + state.ref_consumed;
      result.run_length   = run;
      result.end_position = item.last_char ? (end_base + state.ref_consumed + ref_add) : '0;
      result.record_done  = item.last_char;

      // Record finished: start clean
      if (item.last_char) begin
         state_next = '0;
      end
   end

endmodule

[rtl/cigar_alignment_walker_unit.sv]
// CIGAR walker through two register stages: one character item per cycle unless
// the result side stalls. An item is held in the input register, and any result
// for it is registered in the result register; the cursor adders and run-length
// multiply-add sit between the input register and the result register in a single pass.
// Reset (synchronous, active high) clears cursors, error flag and valids, and
// sets record_position to 1 and window_start to 0.
module cigar_alignment_walker_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  caw_pkg::req_type                    req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output caw_pkg::rsp_type                    rsp_item,
   input  logic                                csr_write_en,
   input  logic [caw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                         csr_wdata
);
   import caw_pkg::*;

   logic           a_valid_ff, a_valid_in;
   req_type        a_item_ff;
   walk_state_type state_ff, state_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_item_ff;
   logic [31:0]    rec_pos_ff, rec_pos_in;
   logic [31:0]    win_start_ff, win_start_in;
   logic [31:0]    col_base_ff, col_base_in;
   logic [31:0]    end_base_ff, end_base_in;

   logic           out_free;
   logic           advance;
   logic           step_emit;
   rsp_type        step_result;

   // Handshake control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = a_valid_ff && out_free;
   assign req_stall = a_valid_ff && !out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   // Configuration; column and end bases are kept precomputed
   always_comb begin
      rec_pos_in   = rec_pos_ff;
      win_start_in = win_start_ff;
      col_base_in  = col_base_ff;
      end_base_in  = end_base_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RECORD_POSITION: begin
               rec_pos_in  = csr_wdata;
               col_base_in = csr_wdata - 32'd1 - win_start_ff;
               end_base_in = csr_wdata - 32'd2;
            end
            CSR_WINDOW_START: begin
               win_start_in = csr_wdata;
               col_base_in  = rec_pos_ff - 32'd1 - csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   caw_step u_step (
      .state      (state_ff),
      .item       (a_item_ff),
      .col_base   (col_base_ff),
      .end_base   (end_base_ff),
      .state_next (state_in),
      .emit       (step_emit),
      .result     (step_result)
   );

   // Next valid flags
   always_comb begin
      a_valid_in = a_valid_ff;
      if (!req_stall) begin
         a_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = advance && step_emit;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         rec_pos_ff   <= 32'd1;
         win_start_ff <= 32'd0;
         col_base_ff  <= 32'd0;
         end_base_ff  <= LEN_MAX;
      end else begin
         a_valid_ff   <= a_valid_in;
         out_valid_ff <= out_valid_in;
         rec_pos_ff   <= rec_pos_in;
         win_start_ff <= win_start_in;
         col_base_ff  <= col_base_in;
         end_base_ff  <= end_base_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         a_item_ff <= req_item;
      end
      if (advance && step_emit) begin
         out_item_ff <= step_result;
      end
   end

   // Checks
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !out_free) |=> a_valid_ff)
      else $error("input register dropped a blocked item");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && a_item_ff.last_char) |=> (state_ff == '0))
      else $error("walker state not cleared after last character");

   a_end_only_when_done: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_item_ff.record_done) |-> (out_item_ff.end_position == '0))
      else $error("end position reported before record end");

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.error_seen && !a_item_ff.last_char) |=> state_ff.error_seen)
      else $error("error flag lost inside a record");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import caw_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 4;
   localparam int TOTAL_CHARS = 1600;

   // Expected segment descriptors, computed from the characters the block accepts
   class segment_scoreboard;
      logic [31:0] rec_pos;
      logic [31:0] win_base;
      logic [31:0] run_acc;
      logic [31:0] read_pos;
      logic [31:0] ref_used;
      bit          in_error;
      rsp_type     expected_segments[$];
      int unsigned mismatches;
      int unsigned checked;
      int unsigned class_count[0:4];

      function new();
         rec_pos = 32'd1;
         win_base = 32'd0;
         mismatches = 0;
         checked = 0;
         foreach (class_count[i]) class_count[i] = 0;
         clear_walk();
      endfunction

      function void clear_walk();
         run_acc = '0;
         read_pos = '0;
         ref_used = '0;
         in_error = 1'b0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [31:0] value);
         if (idx == CSR_RECORD_POSITION)
            rec_pos = value;
         else if (idx == CSR_WINDOW_START)
            win_base = value;
      endfunction

      function int pending();
         return expected_segments.size();
      endfunction

      // Advance the walker by one accepted character; queue a segment if one is due
      function void predict_char(req_type it);
         rsp_type     seg;
         bit          emit;
         bit          adv_read;
         bit          adv_ref;
         logic [63:0] wide;
         seg = '0;
         seg.op_class = OP_CLIP;
         seg.read_offset = read_pos;
         seg.ref_column = rec_pos - 32'd1 - win_base + ref_used;
         emit = 1'b0;
         adv_read = 1'b0;
         adv_ref = 1'b0;
         if (in_error) begin
            // rest of record ignored; only the last char reports
            seg.op_class = OP_BAD;
            emit = it.last_char;
         end else if (it.cigar_char >= CHAR_0 && it.cigar_char <= CHAR_9) begin
            wide = {32'd0, run_acc} * 64'd10 + {56'd0, it.cigar_char - CHAR_0};
            run_acc = (wide > {32'd0, LEN_MAX}) ? LEN_MAX : wide[31:0];
            if (it.last_char) begin
               seg.run_length = run_acc;
               emit = 1'b1;
            end
         end else begin
            seg.run_length = run_acc;
            case (it.cigar_char)
               CHAR_M, CHAR_EQ, CHAR_X: begin
                  seg.op_class = OP_COPY;
                  adv_read = 1'b1;
                  adv_ref = 1'b1;
               end
               CHAR_I, CHAR_S: begin
                  seg.op_class = OP_READ_SKIP;
                  adv_read = 1'b1;
               end
               CHAR_D, CHAR_N: begin
                  seg.op_class = OP_REF_SKIP;
                  adv_ref = 1'b1;
               end
               CHAR_H, CHAR_P: begin
                  seg.op_class = OP_CLIP;
               end
               default: begin
                  seg.op_class = OP_BAD;
                  in_error = 1'b1;
               end
            endcase
            if (adv_read) read_pos = read_pos + run_acc;
            if (adv_ref) ref_used = ref_used + run_acc;
            run_acc = '0;
            emit = 1'b1;
         end
         if (emit) begin
            if (it.last_char) begin
               seg.end_position = rec_pos - 32'd2 + ref_used;
               seg.record_done = 1'b1;
            end
            expected_segments.push_back(seg);
         end
         if (it.last_char) clear_walk();
      endfunction

      task report_mismatch(string what, logic [31:0] got_v, logic [31:0] exp_v);
         $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got_v, exp_v);
         mismatches++;
      endtask

      // Compare one accepted result with the oldest expected segment
      task check_segment(rsp_type got);
         rsp_type exp_seg;
         if (expected_segments.size() == 0) begin
            report_mismatch("result with nothing expected, op_class",
                            32'(got.op_class), 'x);
         end else begin
            exp_seg = expected_segments.pop_front();
            checked++;
            if (got.op_class <= OP_BAD) class_count[got.op_class]++;
            if (got.op_class !== exp_seg.op_class)
               report_mismatch("op_class", 32'(got.op_class), 32'(exp_seg.op_class));
            if (got.read_offset !== exp_seg.read_offset)
               report_mismatch("read_offset", got.read_offset, exp_seg.read_offset);
            if (got.ref_column !== exp_seg.ref_column)
               report_mismatch("ref_column", got.ref_column, exp_seg.ref_column);
            if (got.run_length !== exp_seg.run_length)
               report_mismatch("run_length", got.run_length, exp_seg.run_length);
            if (got.end_position !== exp_seg.end_position)
               report_mismatch("end_position", got.end_position, exp_seg.end_position);
            if (got.record_done !== exp_seg.record_done)
               report_mismatch("record_done", 32'(got.record_done),
                               32'(exp_seg.record_done));
         end
      endtask
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_type                req_item;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_type                rsp_item;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_wdata;

   segment_scoreboard sb;
   int unsigned       send_idle_pct;
   int unsigned       rsp_idle_pct;
   int unsigned       chars_sent;
   int unsigned       records_sent;
   int unsigned       settings_used;
   int unsigned       idle_cycles;
   logic [7:0]        line_q[$];

   cigar_alignment_walker_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random backpressure on the result side
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < rsp_idle_pct);
   end

   // Handshake monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.predict_char(req_item);
         if (rsp_valid && !rsp_stall) sb.check_segment(rsp_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] watchdog: no item moved for %0d cycles, %0d results outstanding",
                     $realtime, idle_cycles, sb.pending());
            $display("** cigar_alignment_walker_unit: FAILED **");
            $finish;
         end
      end
   end

   task automatic send_char(input logic [7:0] ch, input bit last);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= {ch, last};
      do @(posedge clock); while (req_stall);
      chars_sent++;
   endtask

   // Send the queued characters as one record, last flag on the final one
   task automatic send_line();
      foreach (line_q[i]) send_char(line_q[i], i == line_q.size() - 1);
      line_q.delete();
      records_sent++;
   endtask

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   // Wait for all expected results, then let any result-free char drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic [31:0] pos, input logic [31:0] base);
      csr_write_en <= 1'b1;
      csr_index <= CSR_RECORD_POSITION;
      csr_wdata <= pos;
      @(posedge clock);
      sb.write_reg(CSR_RECORD_POSITION, pos);
      csr_index <= CSR_WINDOW_START;
      csr_wdata <= base;
      @(posedge clock);
      sb.write_reg(CSR_WINDOW_START, base);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   task automatic pick_config();
      case ($urandom_range(5, 0))
         0: set_config(32'd1, 32'd0);
         1: set_config(LEN_MAX, LEN_MAX);
         2: set_config(32'd1, LEN_MAX);
         3: set_config(LEN_MAX, 32'd0);
         4: set_config($urandom_range(32'hFFFF_FFFF, 1), $urandom());
         default: set_config($urandom_range(100000, 1), $urandom_range(100000, 0));
      endcase
   endtask

   function automatic logic [7:0] pick_op(int k);
      case (k)
         0: return CHAR_M;
         1: return CHAR_EQ;
         2: return CHAR_X;
         3: return CHAR_I;
         4: return CHAR_S;
         5: return CHAR_D;
         6: return CHAR_N;
         7: return CHAR_H;
         default: return CHAR_P;
      endcase
   endfunction

   // Mostly well-formed CIGAR strings with random lengths, some noise
   function automatic void build_record();
      int              n_ops;
      int              roll;
      longint unsigned big;
      if ($urandom_range(99, 0) < 8) begin
         n_ops = $urandom_range(6, 1);
         repeat (n_ops) line_q.push_back(8'($urandom_range(255, 0)));
      end else begin
         n_ops = $urandom_range(8, 1);
         repeat (n_ops) begin
            roll = $urandom_range(99, 0);
            if (roll < 10) begin
               // no digits: zero-length op
            end else if (roll < 80) begin
               add_text($sformatf("%0d", $urandom_range(999, 0)));
            end else if (roll < 86) begin
               big = {$urandom(), $urandom()};
               big = big >> $urandom_range(63, 20);
               add_text($sformatf("%0d", big));
            end else if (roll < 90) begin
               add_text($urandom_range(1, 0) ? "4294967295" : "4294967296");
            end else begin
               add_text($sformatf("00%0d", $urandom_range(99, 0)));
            end
            if ($urandom_range(99, 0) < 4)
               line_q.push_back(8'($urandom_range(255, 0)));
            else
               line_q.push_back(pick_op($urandom_range(8, 0)));
         end
         // sometimes end the record on a dangling run length
         if ($urandom_range(99, 0) < 6)
            add_text($sformatf("%0d", $urandom_range(99999, 0)));
      end
   endfunction

   initial begin
      int unsigned target;
      int unsigned since_cfg;
      int unsigned cfg_gap;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      chars_sent = 0;
      records_sent = 0;
      settings_used = 0;
      idle_cycles = 0;
      send_idle_pct = 21;
      rsp_idle_pct = 83;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every op class, zero-length ops, bad chars at both byte
      // extremes, a char after an error, saturating digit run ending a record
      add_text("1I2S3D4NHP=X9M");
      send_line();
      line_q.push_back(8'hFF);
      line_q.push_back(8'h00);
      send_line();
      add_text("9999999999");
      send_line();
      wait_idle();
      set_config(LEN_MAX, LEN_MAX);
      add_text("7M0D");
      send_line();
      wait_idle();
      set_config(32'd1, LEN_MAX);

      // Random records in three idling phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 21;
               rsp_idle_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               rsp_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         target = chars_sent + TOTAL_CHARS / 3;
         since_cfg = 0;
         cfg_gap = $urandom_range(12, 4);
         while (chars_sent < target) begin
            if (since_cfg >= cfg_gap) begin
               wait_idle();
               pick_config();
               since_cfg = 0;
               cfg_gap = $urandom_range(12, 4);
            end
            build_record();
            send_line();
            since_cfg++;
         end
         wait_idle();
         pick_config();
      end

      wait_idle();
      $display("Run covered %0d characters in %0d records under %0d register settings;",
               chars_sent, records_sent, settings_used);
      $display("checked %0d segments: copy %0d, read skip %0d, ref skip %0d, clip %0d, bad %0d.",
               sb.checked, sb.class_count[0], sb.class_count[1], sb.class_count[2],
               sb.class_count[3], sb.class_count[4]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("** cigar_alignment_walker_unit: PASSED **");
      end else begin
         $display("** cigar_alignment_walker_unit: FAILED **");
      end
      $finish;
   end

endmodule
